@@ rtl/core/gf256_field_arith_unit_top_assert.svh @@
// Assertion macros shared by the GF(2^8) arithmetic unit RTL.
// Depends on a clk and an rst_n signal in the scope where a macro is used.
`ifndef GF256_FIELD_ARITH_UNIT_TOP_ASSERT_SVH
`define GF256_FIELD_ARITH_UNIT_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define GFAU_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gfau assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define GFAU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gfau assertion failed");

`else

`define GFAU_ASSERT_SAME(label, ante, cons)
`define GFAU_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ rtl/core/gfau_pkg.sv @@
// Types, constants and field helpers for the GF(2^8) arithmetic unit.
// No dependencies; used by the interfaces, the cell and the top level.
package gfau_pkg;

    localparam int GF_BITS     = 8;
    localparam int GF_IDX_W    = 3;
    localparam int NUM_CELLS   = GF_BITS;

    localparam logic [GF_BITS-1:0] GF_REDUCE  = 8'h1b;
    localparam logic [GF_BITS-1:0] GF_TOPBIT  = 8'h80;
    localparam logic [GF_BITS-1:0] GF_INV_EXP = 8'd254;
    localparam logic [GF_BITS-1:0] GF_ONE     = 8'h01;
    localparam logic [GF_BITS-1:0] GF_ZERO    = 8'h00;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_MUL = 2'd1,
        OP_INV = 2'd2
    } gfau_op_t;

    typedef logic [GF_BITS-1:0] gf_byte_t;

    // Work carried from cell to cell: acc is the running result, term is the
    // doubled multiplicand or the repeatedly squared base.
    typedef struct packed {
        gfau_op_t op;
        gf_byte_t acc;
        gf_byte_t term;
        gf_byte_t b;
    } gfau_cell_t;

    function automatic gf_byte_t gf_xtime(input gf_byte_t x);
        gf_byte_t d;
        d = {x[GF_BITS-2:0], 1'b0};
        if ((x & GF_TOPBIT) != GF_ZERO)
            d = d ^ GF_REDUCE;
        return d;
    endfunction

    function automatic gf_byte_t gf_mul(input gf_byte_t a, input gf_byte_t b);
        gf_byte_t acc;
        gf_byte_t term;
        acc  = GF_ZERO;
        term = a;
        for (int i = 0; i < GF_BITS; i++)
        begin
            if (b[i])
                acc = acc ^ term;
            term = gf_xtime(term);
        end
        return acc;
    endfunction

endpackage

@@ rtl/core/gfau_req_if.sv @@
// Request channel of the GF(2^8) arithmetic unit: opcode and two bytes.
// Depends on gfau_pkg for the field width.
interface gfau_req_if import gfau_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [1:0]           opcode;
    logic [GF_BITS-1:0]   operand_a;
    logic [GF_BITS-1:0]   operand_b;

    modport source (output valid, output opcode, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input opcode, input operand_a, input operand_b,
                    output ready);
endinterface

@@ rtl/core/gfau_rsp_if.sv @@
// Result channel of the GF(2^8) arithmetic unit: one result byte.
// Depends on gfau_pkg for the field width.
interface gfau_rsp_if import gfau_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [GF_BITS-1:0]   result_byte;

    modport source (output valid, output result_byte, input ready);
    modport sink   (input valid, input result_byte, output ready);
endinterface

@@ rtl/core/gf256_field_arith_unit_top.sv @@
// Top level of the GF(2^8) arithmetic unit (AES field, x^8+x^4+x^3+x+1).
// Depends on gfau_pkg, gfau_req_if, gfau_rsp_if, gfau_cell and the assert header.
//
//   channel   direction   payload                          handshake
//   req       in          opcode, operand_a, operand_b     valid / ready
//   rsp       out         result_byte                      valid / ready
//
// A request enters a row of eight cells, one per bit of the field element, and
// its result leaves the last cell once it has passed the register of every cell.
// Unless stalled the row takes one request per cycle, paced by each cell's register.
// Each cell has its own valid bit, so a stalled result only holds the cells that
// are full behind it and empty cells keep taking requests.
// Reset clears the valid bits only; no data register is reset.
`include "gf256_field_arith_unit_top_assert.svh"

module gf256_field_arith_unit_top import gfau_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    gfau_req_if.sink   req,
    gfau_rsp_if.source rsp
);

    // Link i feeds cell i; link NUM_CELLS is the output of the last cell.
    logic       link_valid [0:NUM_CELLS];
    logic       link_ready [0:NUM_CELLS];
    gfau_cell_t link_data  [0:NUM_CELLS];

    // Seed the chain. Multiply starts from a zero accumulator and doubles
    // operand_a once per cell; inverse starts from one and squares operand_a
    // once per cell, multiplying in wherever the exponent 254 has a one.
    // Add is finished here and simply rides through the cells, and the
    // unused opcode leaves a zero accumulator that no cell touches.
    always_comb
    begin
        link_data[0].op   = gfau_op_t'(req.opcode);
        link_data[0].term = req.operand_a;
        link_data[0].b    = req.operand_b;
        case (req.opcode)
            OP_ADD:  link_data[0].acc = req.operand_a ^ req.operand_b;
            OP_MUL:  link_data[0].acc = GF_ZERO;
            OP_INV:  link_data[0].acc = GF_ONE;
            default: link_data[0].acc = GF_ZERO;
        endcase
    end

    assign link_valid[0] = req.valid;
    assign req.ready     = link_ready[0];

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        gfau_cell #(
            .STAGE (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (link_valid[i]),
            .up_ready (link_ready[i]),
            .up_data  (link_data[i]),
            .dn_valid (link_valid[i+1]),
            .dn_ready (link_ready[i+1]),
            .dn_data  (link_data[i+1])
        );
    end

    assign rsp.valid        = link_valid[NUM_CELLS];
    assign link_ready[NUM_CELLS] = rsp.ready;
    assign rsp.result_byte  = link_data[NUM_CELLS].acc;

    // An empty first cell must always take a request.
    `GFAU_ASSERT_SAME(a_first_cell_ready, !link_valid[1], req.ready)

    // An accepted request fills the first cell.
    `GFAU_ASSERT_NEXT(a_accept_fills, req.valid && req.ready, link_valid[1])

    // Addition is complete as soon as the request lands in the first cell.
    `GFAU_ASSERT_NEXT(a_add_seeded, req.valid && req.ready && req.opcode == OP_ADD,
        link_data[1].acc == $past(req.operand_a ^ req.operand_b))

    // The squared base is zero only for a zero operand, whose inverse is zero.
    `GFAU_ASSERT_SAME(a_inv_zero,
        rsp.valid && link_data[NUM_CELLS].op == OP_INV &&
        link_data[NUM_CELLS].term == GF_ZERO,
        rsp.result_byte == GF_ZERO)

endmodule

@@ rtl/core/gfau_cell.sv @@
// One cell of the arithmetic chain: a single shift-and-add or square-and-multiply
// step followed by a register stage with its own valid/ready. Depends on gfau_pkg.
module gfau_cell import gfau_pkg::*; #(
    parameter int STAGE = 0
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       up_valid,
    output logic       up_ready,
    input  gfau_cell_t up_data,
    output logic       dn_valid,
    input  logic       dn_ready,
    output gfau_cell_t dn_data
);

    localparam logic [GF_IDX_W-1:0] STAGE_IDX = STAGE[GF_IDX_W-1:0];
    localparam logic                EXP_BIT   = GF_INV_EXP[STAGE_IDX];

    logic       valid_reg;
    logic       valid_next;
    gfau_cell_t data_reg;
    gfau_cell_t data_next;

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        data_next = up_data;
        case (up_data.op)
            OP_MUL:
            begin
                if (up_data.b[STAGE_IDX])
                    data_next.acc = up_data.acc ^ up_data.term;
                data_next.term = gf_xtime(up_data.term);
            end
            OP_INV:
            begin
                if (EXP_BIT)
                    data_next.acc = gf_mul(up_data.acc, up_data.term);
                data_next.term = gf_mul(up_data.term, up_data.term);
            end
            default:
            begin
                data_next = up_data;
            end
        endcase
    end

    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the GF(2^8) arithmetic unit: directed table, then random requests.
// Depends on gfau_pkg, gfau_req_if, gfau_rsp_if and gf256_field_arith_unit_top.
module testbench import gfau_pkg::*; ();

    // Opcode 3 has no operation behind it; the unit must answer it with zero.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int CLK_HALF        = 4;
    localparam int RESET_CYCLES    = 11;
    localparam int NUM_DIRECTED    = 24;
    localparam int NUM_SEGMENTS    = 16;
    localparam int SEGMENT_LEN     = 105;
    localparam int LONG_HOLD       = 300;
    localparam int DRAIN_CYCLES    = 16;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int MAX_REPORTS     = 10;

    // One row of the directed table. When has_literal is set the expected byte is
    // taken from the row itself instead of the predictor.
    typedef struct {
        logic [1:0] code;
        gf_byte_t   a;
        gf_byte_t   b;
        bit         has_literal;
        gf_byte_t   literal;
    } directed_row_t;

    logic clk;
    logic rst_n;

    gfau_req_if req_ch ();
    gfau_rsp_if rsp_ch ();

    gf256_field_arith_unit_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Result bytes still owed by the unit, oldest first.
    gf_byte_t pending_results [$];

    // Side band from the request driver to the monitor: a pinned expectation for
    // the request currently on the bus. Both change only at the falling edge.
    bit       cur_pinned;
    gf_byte_t cur_pinned_value;

    // Idling knobs, in percent per request for gaps and per cycle for stalls. The
    // stimulus process retunes them per segment; zero means the side never idles.
    int gap_pct;
    int stall_pct;
    bit long_hold_req;

    int mismatches;
    int idle_cycles;

    directed_row_t directed_rows [NUM_DIRECTED] = '{
        '{OP_ADD,    8'h00, 8'h00, 1'b1, 8'h00},
        '{OP_ADD,    8'hff, 8'hff, 1'b1, 8'h00},
        '{OP_ADD,    8'hff, 8'h00, 1'b1, 8'hff},
        '{OP_ADD,    8'h00, 8'hff, 1'b1, 8'hff},
        '{OP_ADD,    8'ha5, 8'h5a, 1'b1, 8'hff},
        '{OP_MUL,    8'h00, 8'hff, 1'b1, 8'h00},
        '{OP_MUL,    8'hff, 8'h00, 1'b1, 8'h00},
        '{OP_MUL,    8'h01, 8'hff, 1'b1, 8'hff},
        '{OP_MUL,    8'hff, 8'h01, 1'b1, 8'hff},
        // A single doubling of the top bit folds back in the reduction constant.
        '{OP_MUL,    8'h80, 8'h02, 1'b1, 8'h1b},
        '{OP_MUL,    8'h02, 8'h80, 1'b0, 8'h00},
        '{OP_MUL,    8'hff, 8'hff, 1'b0, 8'h00},
        '{OP_MUL,    8'h57, 8'h83, 1'b0, 8'h00},
        '{OP_MUL,    8'h57, 8'h13, 1'b0, 8'h00},
        // Inverse of zero is defined as zero, and the second byte never matters.
        '{OP_INV,    8'h00, 8'h00, 1'b1, 8'h00},
        '{OP_INV,    8'h00, 8'hff, 1'b1, 8'h00},
        '{OP_INV,    8'h01, 8'h00, 1'b1, 8'h01},
        '{OP_INV,    8'h01, 8'hff, 1'b1, 8'h01},
        '{OP_INV,    8'hff, 8'hff, 1'b0, 8'h00},
        '{OP_INV,    8'h80, 8'h00, 1'b0, 8'h00},
        '{OP_INV,    8'h53, 8'haa, 1'b0, 8'h00},
        '{OP_UNUSED, 8'h00, 8'h00, 1'b1, 8'h00},
        '{OP_UNUSED, 8'hff, 8'hff, 1'b1, 8'h00},
        '{OP_UNUSED, 8'h57, 8'h83, 1'b1, 8'h00}
    };

    // ------------------------------------------------------------------
    // Field arithmetic used to predict each result byte.
    // ------------------------------------------------------------------

    // Multiply by x, reducing modulo x^8 + x^4 + x^3 + x + 1.
    function automatic gf_byte_t field_double(input gf_byte_t x);
        gf_byte_t shifted;
        shifted = {x[GF_BITS-2:0], 1'b0};
        return x[GF_BITS-1] ? (shifted ^ GF_REDUCE) : shifted;
    endfunction

    // Carry-less product: add a doubled copy of a for every set bit of b.
    function automatic gf_byte_t field_product(input gf_byte_t a, input gf_byte_t b);
        gf_byte_t sum;
        gf_byte_t addend;
        sum    = GF_ZERO;
        addend = a;
        for (int k = 0; k < GF_BITS; k++)
        begin
            if (b[k])
                sum = sum ^ addend;
            addend = field_double(addend);
        end
        return sum;
    endfunction

    // a^254 is the inverse of a for every nonzero a and gives zero for zero.
    function automatic gf_byte_t field_reciprocal(input gf_byte_t a);
        gf_byte_t power;
        gf_byte_t square;
        gf_byte_t exponent;
        power    = GF_ONE;
        square   = a;
        exponent = GF_INV_EXP;
        for (int k = 0; k < GF_BITS; k++)
        begin
            if (exponent[k])
                power = field_product(power, square);
            square = field_product(square, square);
        end
        return power;
    endfunction

    function automatic gf_byte_t field_result(input logic [1:0] code, input gf_byte_t a,
                                              input gf_byte_t b);
        case (code)
            OP_ADD:  return a ^ b;
            OP_MUL:  return field_product(a, b);
            OP_INV:  return field_reciprocal(a);
            default: return GF_ZERO;
        endcase
    endfunction

    // Random operand with extra weight on the bytes that tend to expose bugs.
    function automatic gf_byte_t pick_operand();
        case ($urandom_range(0, 11))
            0:       return GF_ZERO;
            1:       return GF_ONE;
            2:       return GF_TOPBIT;
            3:       return 8'hff;
            default: return gf_byte_t'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly the three real operations, with the unused code now and then.
    function automatic logic [1:0] pick_opcode();
        int roll;
        roll = $urandom_range(0, 15);
        if (roll == 0)
            return OP_UNUSED;
        case (roll % 3)
            0:       return OP_ADD;
            1:       return OP_MUL;
            default: return OP_INV;
        endcase
    endfunction

    function automatic int pick_pct();
        return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
    endfunction

    // ------------------------------------------------------------------
    // Clock and reset. Reset is applied once and released at a falling edge.
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_HALF) clk = ~clk;

    initial
    begin
        rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // ------------------------------------------------------------------
    // Request driver. A request is presented at a falling edge and held until a
    // rising edge sees ready; valid stays high across back-to-back requests, so
    // it is only lowered when a gap is inserted or the unit is drained.
    // ------------------------------------------------------------------
    task automatic send_request(input logic [1:0] code, input gf_byte_t a, input gf_byte_t b,
                                input bit pinned, input gf_byte_t pinned_value);
        int gap;
        gap = 0;
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
            gap = $urandom_range(1, 13);
        if (gap > 0)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_ch.valid     <= 1'b1;
        req_ch.opcode    <= code;
        req_ch.operand_a <= a;
        req_ch.operand_b <= b;
        cur_pinned       = pinned;
        cur_pinned_value = pinned_value;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    // Lower valid and wait for the unit to deliver everything it owes.
    task automatic wait_until_drained();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        wait (pending_results.size() == 0);
    endtask

    // ------------------------------------------------------------------
    // Result receiver. Ready drops in short random bursts at the rate set by
    // stall_pct; a long hold-off is requested by the stimulus process and counted
    // here so that the sender keeps pushing while the row of cells fills up.
    // ------------------------------------------------------------------
    initial
    begin
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
            end
            else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 13) - 1) @(negedge clk);
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor. At every rising edge an accepted request adds its expected byte to
    // the back of the queue and an accepted result is checked against the front.
    // A request passes through the register in every cell, so a request and its own
    // result never meet in the same edge. The watchdog counts edges in which work is
    // outstanding but neither channel moves.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input gf_byte_t want, input gf_byte_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s: expected %02h, got %02h", $realtime, what, want, got);
    endtask

    always @(posedge clk)
    begin
        gf_byte_t want;
        bit       moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (req_ch.valid && req_ch.ready)
            begin
                moved = 1'b1;
                if (cur_pinned)
                    pending_results.push_back(cur_pinned_value);
                else
                    pending_results.push_back(field_result(req_ch.opcode, req_ch.operand_a,
                                                           req_ch.operand_b));
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                moved = 1'b1;
                if (pending_results.size() == 0)
                begin
                    report_mismatch("result with no request outstanding", GF_ZERO,
                                    rsp_ch.result_byte);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (rsp_ch.result_byte !== want)
                        report_mismatch("result_byte", want, rsp_ch.result_byte);
                end
            end
            if (!moved && (pending_results.size() != 0 || req_ch.valid))
                idle_cycles++;
            else
                idle_cycles = 0;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus. The directed table runs first with light idling on both sides.
    // The random part follows in segments, each with its own idling rates; one
    // segment has the receiver hold off for a long stretch while the sender keeps
    // offering, another starts only after the unit has emptied, and the last two
    // run with no idling at all.
    // ------------------------------------------------------------------
    initial
    begin
        req_ch.valid     = 1'b0;
        req_ch.opcode    = OP_ADD;
        req_ch.operand_a = GF_ZERO;
        req_ch.operand_b = GF_ZERO;
        cur_pinned       = 1'b0;
        cur_pinned_value = GF_ZERO;
        gap_pct          = 15;
        stall_pct        = 15;
        long_hold_req    = 1'b0;
        mismatches       = 0;
        idle_cycles      = 0;

        @(posedge rst_n);

        foreach (directed_rows[i])
        begin
            send_request(directed_rows[i].code, directed_rows[i].a, directed_rows[i].b,
                         directed_rows[i].has_literal, directed_rows[i].literal);
        end

        for (int seg = 0; seg < NUM_SEGMENTS; seg++)
        begin
            if (seg >= NUM_SEGMENTS - 2)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else if (seg == 2)
            begin
                // Sender runs flat out into a receiver that has stopped.
                gap_pct       = 0;
                stall_pct     = pick_pct();
                long_hold_req = 1'b1;
            end
            else
            begin
                if (seg == 4)
                    wait_until_drained();
                gap_pct   = pick_pct();
                stall_pct = pick_pct();
            end
            for (int n = 0; n < SEGMENT_LEN; n++)
                send_request(pick_opcode(), pick_operand(), pick_operand(), 1'b0, GF_ZERO);
        end

        wait_until_drained();
        // Anything still inside the unit would surface within its latency.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending_results.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
